@@ hdl/lfsa_pkg.sv @@
// Shared constants, codes and types for the lowest free slot allocator.
package lfsa_pkg;

   localparam int SLOT_COUNT = 256;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int PTR_W      = SLOT_W + 1;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WORD_COUNT = SLOT_COUNT / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int SIZE_W     = 13;
   localparam int OFFSET_W   = 20;
   localparam int PROD_W     = SLOT_W + SIZE_W;

   localparam logic [1:0] FUNC_ALLOC  = 2'd0;
   localparam logic [1:0] FUNC_FREE   = 2'd1;
   localparam logic [1:0] FUNC_LOCATE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic                 rd_en;
      logic [WORD_AW-1:0]   rd_addr;
      logic                 wr_en;
      logic [WORD_AW-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } bitmap_req_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } zero_search_type;

endpackage

@@ hdl/lowest_free_slot_allocator.sv @@
// Top level: slot allocator sequencer with lowest-free pointer and word-wise bitmap scan.
//
//  channel | direction | handshake                 | payload
//  req     | in        | req_valid / req_stall     | req_func, req_slot_index
//  rsp     | out       | rsp_valid / rsp_stall     | rsp_status, rsp_granted_index,
//          |           |                           | rsp_byte_offset
//  csr     | in        | csr_wr_en                 | csr_wr_data (element size)
//
//  Locate, free-out-of-range, full and unused kinds pass from idle to the hold state;
//  free adds a bitmap read state, and allocate adds the read state and a scan step
//  for each further 32-slot bitmap word that it has to search.
//  Reset clears the bitmap through per-word valid bits; no clearing pass.
//  A new beat is taken while a finished result waits in the output register.
module lowest_free_slot_allocator
   import lfsa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [SLOT_W-1:0]   req_slot_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [SLOT_W-1:0]   rsp_granted_index,
   output logic [OFFSET_W-1:0] rsp_byte_offset,
   input  logic                csr_wr_en,
   input  logic [SIZE_W-1:0]   csr_wr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);
   localparam logic [PTR_W-1:0]   PTR_FULL  = PTR_W'(SLOT_COUNT);

   function automatic zero_search_type find_first_zero(input logic [WORD_BITS-1:0] word);
      zero_search_type res;
      res = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            res.found = 1'b1;
            res.pos   = BIT_W'(i);
         end
      end
      return res;
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic [1:0]          func_ff, func_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [WORD_AW-1:0]  scan_addr_ff, scan_addr_in;
   logic [SIZE_W-1:0]   element_size_ff;
   logic [1:0]          res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_index_ff, res_index_in;
   logic [OFFSET_W-1:0] res_offset_ff, res_offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;

   bitmap_req_type       bm_req;
   logic [WORD_BITS-1:0] rd_data;

   logic [WORD_AW-1:0]   ptr_word;
   logic [BIT_W-1:0]     ptr_bit;
   logic [WORD_BITS-1:0] alloc_word;
   logic [WORD_BITS-1:0] le_mask;
   zero_search_type      alloc_search;
   zero_search_type      scan_search;
   logic [PROD_W-1:0]    product;
   logic                 req_in_range;

   lfsa_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .bm_req  (bm_req),
      .rd_data (rd_data)
   );

   assign ptr_word     = ptr_ff[SLOT_W-1:BIT_W];
   assign ptr_bit      = ptr_ff[BIT_W-1:0];
   assign alloc_word   = rd_data | (WORD_BITS'(1) << ptr_bit);
   assign le_mask      = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - ptr_bit);
   assign alloc_search = find_first_zero(alloc_word | le_mask);
   assign scan_search  = find_first_zero(rd_data);
   assign product      = PROD_W'(req_slot_index) * PROD_W'(element_size_ff);
   assign req_in_range = {1'b0, req_slot_index} < PTR_FULL;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      scan_addr_in  = scan_addr_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_offset_in = res_offset_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;
      bm_req        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               idx_in        = req_slot_index;
               res_status_in = STATUS_OK;
               res_index_in  = '0;
               res_offset_in = '0;
               state_in      = ST_HOLD;
               case (req_func)
                  FUNC_ALLOC: begin
                     if (ptr_ff >= PTR_FULL) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        res_index_in   = ptr_ff[SLOT_W-1:0];
                        bm_req.rd_en   = 1'b1;
                        bm_req.rd_addr = ptr_word;
                        state_in       = ST_READ;
                     end
                  end
                  FUNC_FREE: begin
                     if (!req_in_range) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        bm_req.rd_en   = 1'b1;
                        bm_req.rd_addr = req_slot_index[SLOT_W-1:BIT_W];
                        state_in       = ST_READ;
                     end
                  end
                  FUNC_LOCATE: begin
                     if (!req_in_range) begin
                        res_status_in = STATUS_RANGE;
                     end else begin
                        res_offset_in = product[OFFSET_W-1:0];
                     end
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_HOLD;
            if (func_ff == FUNC_ALLOC) begin
               bm_req.wr_en   = 1'b1;
               bm_req.wr_addr = ptr_word;
               bm_req.wr_data = alloc_word;
               if (alloc_search.found) begin
                  ptr_in = {1'b0, ptr_word, alloc_search.pos};
               end else if (ptr_word == LAST_WORD) begin
                  ptr_in = PTR_FULL;
               end else begin
                  bm_req.rd_en   = 1'b1;
                  bm_req.rd_addr = ptr_word + WORD_AW'(1);
                  scan_addr_in   = ptr_word + WORD_AW'(1);
                  state_in       = ST_SCAN;
               end
            end else begin
               // drop the flag of a used slot, pull the pointer down
               if (rd_data[idx_ff[BIT_W-1:0]]) begin
                  bm_req.wr_en   = 1'b1;
                  bm_req.wr_addr = idx_ff[SLOT_W-1:BIT_W];
                  bm_req.wr_data = rd_data & ~(WORD_BITS'(1) << idx_ff[BIT_W-1:0]);
                  if ({1'b0, idx_ff} < ptr_ff) begin
                     ptr_in = {1'b0, idx_ff};
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_search.found) begin
               ptr_in   = {1'b0, scan_addr_ff, scan_search.pos};
               state_in = ST_HOLD;
            end else if (scan_addr_ff == LAST_WORD) begin
               ptr_in   = PTR_FULL;
               state_in = ST_HOLD;
            end else begin
               bm_req.rd_en   = 1'b1;
               bm_req.rd_addr = scan_addr_ff + WORD_AW'(1);
               scan_addr_in   = scan_addr_ff + WORD_AW'(1);
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_offset_in = res_offset_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ptr_ff          <= PTR_W'(1);
         element_size_ff <= SIZE_W'(1);
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            element_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      scan_addr_ff  <= scan_addr_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_index_ff;
   assign rsp_byte_offset   = rsp_offset_ff;

   a_ptr_nonzero: assert property (@(posedge clock) disable iff (reset)
      ptr_ff != '0)
      else $error("free pointer reached the reserved slot");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= PTR_FULL)
      else $error("free pointer beyond capacity");

   a_grant_or_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_index_ff == '0 || rsp_offset_ff == '0))
      else $error("result carries both a grant and an offset");

   a_full_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (rsp_index_ff == '0))
      else $error("failed request carries a granted index");

endmodule

@@ hdl/lfsa_bitmap.sv @@
// Used-flag bitmap: word memory with per-word valid bits and registered read data.
module lfsa_bitmap
   import lfsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  bitmap_req_type       bm_req,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0]  word_mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;
   logic [WORD_BITS-1:0]  rd_word_ff;
   logic                  rd_valid_ff;

   always_ff @(posedge clock) begin
      if (bm_req.wr_en) begin
         word_mem[bm_req.wr_addr] <= bm_req.wr_data;
      end
      if (bm_req.rd_en) begin
         rd_word_ff <= word_mem[bm_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (bm_req.wr_en) begin
            valid_ff[bm_req.wr_addr] <= 1'b1;
         end
         if (bm_req.rd_en) begin
            rd_valid_ff <= valid_ff[bm_req.rd_addr];
         end
      end
   end

   // unwritten words read as all free
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

   a_no_same_word_rw: assert property (@(posedge clock) disable iff (reset)
      (bm_req.wr_en && bm_req.rd_en) |-> (bm_req.wr_addr != bm_req.rd_addr))
      else $error("bitmap read and write hit the same word");

endmodule
